FILE: hw/rtl/abf_pkg.sv
package abf_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned IdxW  = 4;

    localparam logic [DataW-1:0] ALL_ONES = '1;

    localparam logic [2:0] CMD_READ_REG   = 3'd0;
    localparam logic [2:0] CMD_WRITE_REG  = 3'd1;
    localparam logic [2:0] CMD_READ_CPSR  = 3'd2;
    localparam logic [2:0] CMD_WRITE_CPSR = 3'd3;
    localparam logic [2:0] CMD_READ_SPSR  = 3'd4;
    localparam logic [2:0] CMD_WRITE_SPSR = 3'd5;

    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    localparam logic [3:0] REG_FIRST_BANKED = 4'd8;
    localparam logic [3:0] REG_LAST_FIQ     = 4'd12;
    localparam logic [3:0] REG_LR           = 4'd14;
    localparam logic [3:0] SP_LR_ROW        = 4'd6;

    localparam logic [DataW-1:0] CPSR_RESET = {{(DataW-5){1'b0}}, MODE_SVC};

    typedef struct packed {
        logic [2:0]       cmd;
        logic [3:0]       reg_index;
        logic [4:0]       access_mode;
        logic [DataW-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [DataW-1:0] read_data;
        logic             access_error;
        logic [4:0]       active_mode;
        logic             current_has_spsr;
        logic             privileged;
    } t_out_item;

    typedef enum logic [2:0] {
        TGT_NONE,
        TGT_LOW,
        TGT_FIQ_BANK,
        TGT_SP_LR,
        TGT_CPSR,
        TGT_SPSR
    } t_target;

    typedef struct packed {
        t_target          target;
        logic [IdxW-1:0]  index;
        logic             is_write;
        logic             err;
    } t_access;

    // bit 3 flags a valid group, bits 2:0 hold the r13/r14 bank group
    function automatic logic [3:0] sp_lr_group(input logic [4:0] mode);
        logic [3:0] g;
        unique case (mode)
            MODE_USR, MODE_SYS: g = 4'b1000;
            MODE_FIQ:           g = 4'b1001;
            MODE_IRQ:           g = 4'b1010;
            MODE_SVC:           g = 4'b1011;
            MODE_UND:           g = 4'b1100;
            MODE_ABT:           g = 4'b1101;
            default:            g = 4'b0000;
        endcase
        return g;
    endfunction

    // bit 3 flags a valid slot, bits 2:0 hold the SPSR slot
    function automatic logic [3:0] spsr_slot(input logic [4:0] mode);
        logic [3:0] s;
        unique case (mode)
            MODE_FIQ: s = 4'b1000;
            MODE_IRQ: s = 4'b1001;
            MODE_SVC: s = 4'b1010;
            MODE_ABT: s = 4'b1011;
            MODE_UND: s = 4'b1100;
            default:  s = 4'b0000;
        endcase
        return s;
    endfunction

    function automatic logic is_privileged(input logic [4:0] mode);
        return !((mode == MODE_USR) || (mode == MODE_SYS));
    endfunction

endpackage

FILE: hw/rtl/abf_decode.sv
module abf_decode
    import abf_pkg::*;
(
    input  t_in_item i_item,
    output t_access  o_acc
);

    logic [3:0] w_grp;
    logic [3:0] w_slot;

    assign w_grp  = sp_lr_group(i_item.access_mode);
    assign w_slot = spsr_slot(i_item.access_mode);

    always_comb begin
        o_acc.target   = TGT_NONE;
        o_acc.index    = '0;
        o_acc.is_write = 1'b0;
        o_acc.err      = 1'b0;
        unique case (i_item.cmd)
            CMD_READ_REG, CMD_WRITE_REG: begin
                o_acc.is_write = (i_item.cmd == CMD_WRITE_REG);
                if (i_item.reg_index < REG_FIRST_BANKED) begin
                    o_acc.target = TGT_LOW;
                    o_acc.index  = {1'b0, i_item.reg_index[2:0]};
                end else if (i_item.reg_index <= REG_LAST_FIQ) begin
                    // row per register, column picks the FIQ copy
                    o_acc.target = TGT_FIQ_BANK;
                    o_acc.index  = {i_item.reg_index[2:0],
                                    i_item.access_mode == MODE_FIQ};
                end else if ((i_item.reg_index <= REG_LR) && w_grp[3]) begin
                    o_acc.target = TGT_SP_LR;
                    o_acc.index  = {1'b0, w_grp[2:0]}
                                 + ((i_item.reg_index == REG_LR) ? SP_LR_ROW : 4'd0);
                end else begin
                    o_acc.err = 1'b1;
                end
            end
            CMD_READ_CPSR, CMD_WRITE_CPSR: begin
                o_acc.target   = TGT_CPSR;
                o_acc.is_write = (i_item.cmd == CMD_WRITE_CPSR);
            end
            CMD_READ_SPSR, CMD_WRITE_SPSR: begin
                o_acc.is_write = (i_item.cmd == CMD_WRITE_SPSR);
                if (w_slot[3]) begin
                    o_acc.target = TGT_SPSR;
                    o_acc.index  = {1'b0, w_slot[2:0]};
                end else begin
                    o_acc.err = 1'b1;
                end
            end
            default: begin
                o_acc.err = 1'b1;
            end
        endcase
    end

endmodule

FILE: hw/rtl/abf_regs.sv
module abf_regs
    import abf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_access          i_acc,
    input  logic [DataW-1:0] i_write_data,
    output logic [DataW-1:0] o_read_data,
    output logic [DataW-1:0] o_cpsr
);

    logic [DataW-1:0] r_low  [8];
    logic [DataW-1:0] r_fiqb [10];
    logic [DataW-1:0] r_splr [12];
    logic [DataW-1:0] r_spsr [5];
    logic [DataW-1:0] r_cpsr;
    logic             w_we;

    assign w_we   = i_en && i_acc.is_write && !i_acc.err;
    assign o_cpsr = r_cpsr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_low[i] <= '0;
            for (int i = 0; i < 10; i++) r_fiqb[i] <= '0;
            for (int i = 0; i < 12; i++) r_splr[i] <= '0;
            for (int i = 0; i < 5; i++) r_spsr[i] <= '0;
            r_cpsr <= CPSR_RESET;
        end else if (w_we) begin
            unique case (i_acc.target)
                TGT_LOW:      r_low[i_acc.index[2:0]] <= i_write_data;
                TGT_FIQ_BANK: r_fiqb[i_acc.index]     <= i_write_data;
                TGT_SP_LR:    r_splr[i_acc.index]     <= i_write_data;
                TGT_CPSR:     r_cpsr                  <= i_write_data;
                TGT_SPSR:     r_spsr[i_acc.index[2:0]] <= i_write_data;
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (i_acc.target)
            TGT_LOW:      o_read_data = r_low[i_acc.index[2:0]];
            TGT_FIQ_BANK: o_read_data = r_fiqb[i_acc.index];
            TGT_SP_LR:    o_read_data = r_splr[i_acc.index];
            TGT_CPSR:     o_read_data = r_cpsr;
            TGT_SPSR:     o_read_data = r_spsr[i_acc.index[2:0]];
            default:      o_read_data = ALL_ONES;
        endcase
    end

endmodule

FILE: hw/rtl/arm_banked_register_file.sv
// Banked ARMv5 register file: one access per transaction (r0-r14 under an
// explicit mode, CPSR, or SPSR under an explicit mode), one result per
// transaction. Throughput is one transaction per cycle when the result side is
// ready; a transaction is held in the input register and then in the result
// register, with the decode and the register-file read or write between
// them. Writes take effect as the transaction moves into the result register,
// so a following read sees them. Invalid registers or modes return all ones
// with access_error set and write nothing; write commands always return all
// ones. Every result reports the mode held in CPSR bits 4:0 after the access,
// whether that mode owns an SPSR, and whether it is privileged. Reset puts
// CPSR at 0x13 (SVC) and clears all other registers.
module arm_banked_register_file
    import abf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic             r_in_valid;
    t_in_item         r_in_item;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        n_out_item;

    logic             w_advance;
    t_access          w_acc;
    logic [DataW-1:0] w_rd;
    logic [DataW-1:0] w_cpsr;
    logic [4:0]       w_mode;
    logic [3:0]       w_slot;

    // Move the held transaction forward when the result register is free
    // or being emptied this cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    abf_decode u_decode (
        .i_item (r_in_item),
        .o_acc  (w_acc)
    );

    abf_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_advance),
        .i_acc        (w_acc),
        .i_write_data (r_in_item.write_data),
        .o_read_data  (w_rd),
        .o_cpsr       (w_cpsr)
    );

    // Current mode after this access: a CPSR write shows its new mode at once.
    assign w_mode = (w_acc.target == TGT_CPSR && w_acc.is_write)
                  ? r_in_item.write_data[4:0] : w_cpsr[4:0];
    assign w_slot = spsr_slot(w_mode);

    always_comb begin
        n_out_item.read_data        = (w_acc.is_write || w_acc.err) ? ALL_ONES : w_rd;
        n_out_item.access_error     = w_acc.err;
        n_out_item.active_mode      = w_mode;
        n_out_item.current_has_spsr = w_slot[3];
        n_out_item.privileged       = is_privileged(w_mode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: test/arm_banked_register_file_checker.sv
`timescale 1ns / 100ps

module arm_banked_register_file_checker
    import abf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_outstanding,
    output int        o_mismatches
);

    // Shadow copy of the architectural state
    logic [DataW-1:0] low_regs       [8];
    logic [DataW-1:0] fiq_split_regs [10];  // (reg - 8) * 2 + (1 for FIQ)
    logic [DataW-1:0] sp_lr_regs     [12];  // (0 for r13, 6 for r14) + bank
    logic [DataW-1:0] cpsr;
    logic [DataW-1:0] spsr_regs      [5];

    t_out_item pending_results [$];

    function automatic int sp_lr_bank(input logic [4:0] mode);
        case (mode)
            MODE_USR, MODE_SYS: return 0;
            MODE_FIQ:           return 1;
            MODE_IRQ:           return 2;
            MODE_SVC:           return 3;
            MODE_UND:           return 4;
            MODE_ABT:           return 5;
            default:            return -1;
        endcase
    endfunction

    function automatic int spsr_slot_of(input logic [4:0] mode);
        case (mode)
            MODE_FIQ: return 0;
            MODE_IRQ: return 1;
            MODE_SVC: return 2;
            MODE_ABT: return 3;
            MODE_UND: return 4;
            default:  return -1;
        endcase
    endfunction

    // Apply one access to the shadow state and return the result it gives.
    function automatic t_out_item apply_access(input t_in_item acc);
        t_out_item res;
        int        grp;
        int        slot;
        logic      is_wr;
        res           = '0;
        res.read_data = ALL_ONES;
        is_wr         = (acc.cmd == CMD_WRITE_REG);
        case (acc.cmd)
            CMD_READ_REG, CMD_WRITE_REG: begin
                grp = sp_lr_bank(acc.access_mode);
                if (acc.reg_index < REG_FIRST_BANKED) begin
                    slot = int'(acc.reg_index);
                    if (is_wr) low_regs[slot] = acc.write_data;
                    else res.read_data = low_regs[slot];
                end else if (acc.reg_index <= REG_LAST_FIQ) begin
                    // any mode but FIQ, defined or not, lands in the common bank
                    slot = 2 * (int'(acc.reg_index) - int'(REG_FIRST_BANKED))
                         + ((acc.access_mode == MODE_FIQ) ? 1 : 0);
                    if (is_wr) fiq_split_regs[slot] = acc.write_data;
                    else res.read_data = fiq_split_regs[slot];
                end else if (acc.reg_index <= REG_LR && grp >= 0) begin
                    slot = ((acc.reg_index == REG_LR) ? int'(SP_LR_ROW) : 0) + grp;
                    if (is_wr) sp_lr_regs[slot] = acc.write_data;
                    else res.read_data = sp_lr_regs[slot];
                end else begin
                    res.access_error = 1'b1;
                end
            end
            CMD_READ_CPSR:  res.read_data = cpsr;
            CMD_WRITE_CPSR: cpsr = acc.write_data;
            CMD_READ_SPSR, CMD_WRITE_SPSR: begin
                slot = spsr_slot_of(acc.access_mode);
                if (slot < 0) res.access_error = 1'b1;
                else if (acc.cmd == CMD_WRITE_SPSR) spsr_regs[slot] = acc.write_data;
                else res.read_data = spsr_regs[slot];
            end
            default: res.access_error = 1'b1;
        endcase
        res.active_mode      = cpsr[4:0];
        res.current_has_spsr = (spsr_slot_of(cpsr[4:0]) >= 0);
        res.privileged       = !((cpsr[4:0] == MODE_USR) || (cpsr[4:0] == MODE_SYS));
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                   input logic [DataW-1:0] want);
        $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin : track
        t_out_item want;
        if (!i_rst_n) begin
            foreach (low_regs[i]) low_regs[i] = '0;
            foreach (fiq_split_regs[i]) fiq_split_regs[i] = '0;
            foreach (sp_lr_regs[i]) sp_lr_regs[i] = '0;
            foreach (spsr_regs[i]) spsr_regs[i] = '0;
            cpsr = CPSR_RESET;
            pending_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                pending_results.push_back(apply_access(i_in_item));
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unrequested result, read_data", i_out_item.read_data, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_item.read_data !== want.read_data)
                        report_mismatch("read_data", i_out_item.read_data, want.read_data);
                    if (i_out_item.access_error !== want.access_error)
                        report_mismatch("access_error", i_out_item.access_error,
                                        want.access_error);
                    if (i_out_item.active_mode !== want.active_mode)
                        report_mismatch("active_mode", i_out_item.active_mode,
                                        want.active_mode);
                    if (i_out_item.current_has_spsr !== want.current_has_spsr)
                        report_mismatch("current_has_spsr", i_out_item.current_has_spsr,
                                        want.current_has_spsr);
                    if (i_out_item.privileged !== want.privileged)
                        report_mismatch("privileged", i_out_item.privileged,
                                        want.privileged);
                end
            end
        end
        o_outstanding = pending_results.size();
    end

endmodule

FILE: test/arm_banked_register_file_tb.sv
`timescale 1ns / 100ps

module arm_banked_register_file_tb;
    import abf_pkg::*;

    // Register numbers and codes that the package does not name
    localparam logic [3:0] REG_SP       = 4'd13;
    localparam logic [3:0] REG_PC       = 4'd15;
    localparam logic [2:0] CMD_RSVD_6   = 3'd6;
    localparam logic [2:0] CMD_RSVD_7   = 3'd7;
    localparam logic [4:0] MODE_ZERO    = 5'h00;
    localparam logic [4:0] MODE_RSVD    = 5'h14;

    localparam int RANDOM_ACCESSES = 400;
    localparam int QUIET_TAIL      = 80;   // final transactions with no idling
    localparam int LONG_HOLD       = 60;   // cycles the result side holds off
    localparam int HOLD_AT         = 60;   // random transaction that triggers the hold
    localparam int DRAIN_AT        = 200;  // random transaction that waits for a drain

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    int        outstanding;
    int        mismatches;

    bit quiet;         // set: no idling on either side
    bit hold_request;  // set by the stimulus, taken by the result sink

    logic [4:0] defined_modes [7] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
                                      MODE_ABT, MODE_UND, MODE_SYS};

    arm_banked_register_file u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // Watch both channels, predict every result and compare
    arm_banked_register_file_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .o_outstanding (outstanding),
        .o_mismatches  (mismatches)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop in case the block hangs or loses a result
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_in_item make_access(input logic [2:0] c, input logic [3:0] idx,
                                             input logic [4:0] mode,
                                             input logic [DataW-1:0] data);
        t_in_item acc;
        acc.cmd         = c;
        acc.reg_index   = idx;
        acc.access_mode = mode;
        acc.write_data  = data;
        return acc;
    endfunction

    // Mostly defined modes and valid registers; the rest covers every
    // encoding so each bit of each field toggles.
    function automatic t_in_item random_access();
        int               pick;
        logic [2:0]       c;
        logic [3:0]       idx;
        logic [4:0]       mode;
        logic [DataW-1:0] data;
        pick = $urandom_range(0, 99);
        mode = ($urandom_range(0, 3) != 0) ? defined_modes[$urandom_range(0, 6)]
                                           : 5'($urandom);
        idx  = ($urandom_range(0, 15) != 0) ? 4'($urandom_range(0, 14)) : REG_PC;
        case ($urandom_range(0, 9))
            0:       data = '0;
            1:       data = '1;
            default: data = $urandom;
        endcase
        if (pick < 35)      c = CMD_READ_REG;
        else if (pick < 65) c = CMD_WRITE_REG;
        else if (pick < 72) c = CMD_READ_CPSR;
        else if (pick < 80) begin
            c = CMD_WRITE_CPSR;
            // keep the current mode defined most of the time
            if ($urandom_range(0, 4) != 0) data[4:0] = defined_modes[$urandom_range(0, 6)];
        end
        else if (pick < 88) c = CMD_READ_SPSR;
        else if (pick < 96) c = CMD_WRITE_SPSR;
        else if (pick < 98) c = CMD_RSVD_6;
        else                c = CMD_RSVD_7;
        return make_access(c, idx, mode, data);
    endfunction

    // Present one transaction at the falling edge and hold it until accepted
    task automatic offer(input t_in_item acc);
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= acc;
        do @(posedge clk); while (in_ready !== 1'b1);
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    // Result sink: random stall bursts, an occasional long hold-off, and
    // a steady ready once the run goes quiet.
    initial begin : result_sink
        int burst;
        int hold;
        bit hold_taken;
        burst      = 0;
        hold       = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request && !hold_taken) begin
                hold       = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end else if (quiet) begin
                out_ready <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                out_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 7) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_in_item directed [$];
        in_valid     = 1'b0;
        in_item      = '0;
        rst_n        = 1'b0;
        quiet        = 1'b0;
        hold_request = 1'b0;

        // Extremes of the data, banking of every register range, bad
        // registers and modes, SPSR of modes without one, reserved commands,
        // and CPSR writes that move the current mode around.
        directed.push_back(make_access(CMD_READ_CPSR,  4'd0,   MODE_USR,  '0));
        directed.push_back(make_access(CMD_WRITE_REG,  4'd0,   MODE_USR,  '1));
        directed.push_back(make_access(CMD_READ_REG,   4'd0,   MODE_ZERO, '0));
        directed.push_back(make_access(CMD_WRITE_REG,  4'd8,   MODE_FIQ,  32'hA5A5_A5A5));
        directed.push_back(make_access(CMD_WRITE_REG,  4'd12,  MODE_ZERO, 32'h5A5A_5A5A));
        directed.push_back(make_access(CMD_READ_REG,   4'd8,   MODE_USR,  '1));
        directed.push_back(make_access(CMD_READ_REG,   4'd8,   MODE_FIQ,  '0));
        directed.push_back(make_access(CMD_READ_REG,   4'd12,  MODE_RSVD, '0));
        directed.push_back(make_access(CMD_WRITE_REG,  REG_SP, MODE_IRQ,  32'h1234_5678));
        directed.push_back(make_access(CMD_WRITE_REG,  REG_LR, MODE_UND,  32'h8765_4321));
        directed.push_back(make_access(CMD_WRITE_REG,  REG_SP, MODE_ZERO, 32'hFFFF_0000));
        directed.push_back(make_access(CMD_READ_REG,   REG_LR, MODE_RSVD, '0));
        directed.push_back(make_access(CMD_READ_REG,   REG_SP, MODE_IRQ,  '0));
        directed.push_back(make_access(CMD_READ_REG,   REG_LR, MODE_UND,  '0));
        directed.push_back(make_access(CMD_WRITE_REG,  REG_PC, MODE_SVC,  32'hDEAD_BEEF));
        directed.push_back(make_access(CMD_READ_REG,   REG_PC, MODE_SVC,  '0));
        directed.push_back(make_access(CMD_WRITE_SPSR, 4'd0,   MODE_IRQ,  32'hCAFE_F00D));
        directed.push_back(make_access(CMD_READ_SPSR,  4'd0,   MODE_IRQ,  '0));
        directed.push_back(make_access(CMD_READ_SPSR,  4'd0,   MODE_USR,  '0));
        directed.push_back(make_access(CMD_WRITE_SPSR, 4'd0,   MODE_SYS,  '1));
        directed.push_back(make_access(CMD_RSVD_6,     4'd1,   MODE_SVC,  '1));
        directed.push_back(make_access(CMD_RSVD_7,     4'd1,   MODE_SVC,  '1));
        directed.push_back(make_access(CMD_WRITE_CPSR, 4'd0,   MODE_USR,  {27'h0, MODE_USR}));
        directed.push_back(make_access(CMD_WRITE_CPSR, 4'd0,   MODE_USR,
                                       {27'h7FF_FFFF, MODE_RSVD}));
        directed.push_back(make_access(CMD_WRITE_CPSR, 4'd0,   MODE_USR,  '1));
        directed.push_back(make_access(CMD_WRITE_CPSR, 4'd0,   MODE_USR,  CPSR_RESET));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i]) begin
            if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 7));
            offer(directed[i]);
        end

        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            // Hold off the result side while transactions keep coming, so
            // the block fills up and backs up its input.
            if (n == HOLD_AT) hold_request = 1'b1;
            // Pause the sender once until every result is back
            if (n == DRAIN_AT) drain();
            if (n == RANDOM_ACCESSES - QUIET_TAIL) quiet = 1'b1;
            if (!quiet && $urandom_range(0, 4) == 0) idle_sender($urandom_range(1, 7));
            offer(random_access());
        end

        drain();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
